// ===== rtl/core/fdtdh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdtdh_pkg
// Shared constants, register codes and types of the H field update block.
// ----------------------------------------------------------------------------
package fdtdh_pkg;

   localparam int MAX_GRID    = 64;
   localparam int STRIDE      = MAX_GRID + 1;
   localparam int STORE_DEPTH = MAX_GRID * STRIDE;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int LINE_W      = $clog2(STRIDE);

   localparam int POS_W       = 7;
   localparam int GRID_W      = 7;
   localparam int DATA_W      = 32;
   localparam int COEF_W      = 32;
   localparam int COEF_FRAC   = 24;
   localparam int DIFF_W      = DATA_W + 1;
   localparam int PROD_W      = DATA_W + COEF_W;
   localparam int QUOT_W      = PROD_W - COEF_FRAC;
   localparam int SUM_W       = QUOT_W + 2;

   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_IDX_W   = 1;

   localparam logic [CSR_IDX_W-1:0] REG_GRID_SIZE   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COEFFICIENT = 1'd1;

   localparam logic [GRID_W-1:0] GRID_MIN   = GRID_W'(2);
   localparam logic [GRID_W-1:0] GRID_MAX   = GRID_W'(MAX_GRID);
   localparam logic [GRID_W-1:0] GRID_RESET = GRID_W'(64);
   localparam logic [COEF_W-1:0] COEF_RESET = COEF_W'(22315);

   typedef struct packed {
      logic [GRID_W-1:0] grid_size;
      logic [COEF_W-1:0] coefficient;
   } cfg_type;

   typedef struct packed {
      logic              advance;
      logic              accept;
      logic              clearing;
      logic [ADDR_W-1:0] clear_addr;
   } pipe_ctl_type;

   typedef struct packed {
      logic             vld;
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
      logic             hy_en;
      logic             hx_en;
      logic             last;
   } stage_type;

endpackage

// ===== rtl/core/fdtdh_csr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdtdh_csr
// Configuration registers: grid size and update coefficient, APB access.
// ----------------------------------------------------------------------------
module fdtdh_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [fdtdh_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [fdtdh_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [fdtdh_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                                pready,
   output fdtdh_pkg::cfg_type                  cfg
);

   fdtdh_pkg::cfg_type               cfg_ff;
   logic [fdtdh_pkg::CSR_IDX_W-1:0]  reg_idx;
   logic                             wr_en;

   assign reg_idx = paddr[2 +: fdtdh_pkg::CSR_IDX_W];
   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grid_size   <= fdtdh_pkg::GRID_RESET;
         cfg_ff.coefficient <= fdtdh_pkg::COEF_RESET;
      end else if (wr_en) begin
         case (reg_idx)
            fdtdh_pkg::REG_GRID_SIZE: begin
               cfg_ff.grid_size <= pwdata[fdtdh_pkg::GRID_W-1:0];
            end
            fdtdh_pkg::REG_COEFFICIENT: begin
               cfg_ff.coefficient <= pwdata[fdtdh_pkg::COEF_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         fdtdh_pkg::REG_GRID_SIZE: begin
            prdata = fdtdh_pkg::CSR_DATA_W'(cfg_ff.grid_size);
         end
         fdtdh_pkg::REG_COEFFICIENT: begin
            prdata = fdtdh_pkg::CSR_DATA_W'(cfg_ff.coefficient);
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/core/fdtdh_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdtdh_scan
// Raster position tracking, Ez line buffer and previous-sample register.
// ----------------------------------------------------------------------------
module fdtdh_scan (
   input  logic                               clock,
   input  logic                               reset,
   input  fdtdh_pkg::pipe_ctl_type            ctl,
   input  logic [fdtdh_pkg::GRID_W-1:0]       grid_size,
   input  logic [fdtdh_pkg::DATA_W-1:0]       ez_value,
   input  logic                               frame_start,
   output logic [fdtdh_pkg::ADDR_W-1:0]       hy_addr,
   output logic [fdtdh_pkg::ADDR_W-1:0]       hx_addr,
   output fdtdh_pkg::stage_type               meta_s1,
   output logic [fdtdh_pkg::DATA_W-1:0]       ez_s1,
   output logic [fdtdh_pkg::DATA_W-1:0]       line_s1,
   output logic [fdtdh_pkg::DATA_W-1:0]       prev_s1
);

   logic [fdtdh_pkg::DATA_W-1:0] line_mem [fdtdh_pkg::STRIDE];

   logic [fdtdh_pkg::POS_W-1:0]  row_ff, col_ff, row_in, col_in;
   logic [fdtdh_pkg::DATA_W-1:0] prev_ez_ff;
   logic [fdtdh_pkg::DATA_W-1:0] ez_s1_ff, line_s1_ff, prev_s1_ff;
   fdtdh_pkg::stage_type         meta_s1_ff, meta_in;

   logic [fdtdh_pkg::GRID_W-1:0] n;
   logic [fdtdh_pkg::POS_W-1:0]  r_pick, c_pick, r, c;
   logic [fdtdh_pkg::ADDR_W-1:0] r_ext, c_ext;
   logic [fdtdh_pkg::LINE_W-1:0] line_idx;

   always_comb begin
      if (grid_size < fdtdh_pkg::GRID_MIN) begin
         n = fdtdh_pkg::GRID_MIN;
      end else if (grid_size > fdtdh_pkg::GRID_MAX) begin
         n = fdtdh_pkg::GRID_MAX;
      end else begin
         n = grid_size;
      end

      r_pick = frame_start ? '0 : row_ff;
      c_pick = frame_start ? '0 : col_ff;
      if (r_pick > n || c_pick > n) begin
         r = '0;
         c = '0;
      end else begin
         r = r_pick;
         c = c_pick;
      end

      r_ext    = fdtdh_pkg::ADDR_W'(r);
      c_ext    = fdtdh_pkg::ADDR_W'(c);
      hy_addr  = (r_ext - fdtdh_pkg::ADDR_W'(1)) * fdtdh_pkg::ADDR_W'(fdtdh_pkg::STRIDE)
               + c_ext;
      hx_addr  = r_ext * fdtdh_pkg::ADDR_W'(fdtdh_pkg::STRIDE) + c_ext
               - fdtdh_pkg::ADDR_W'(1);
      line_idx = c[fdtdh_pkg::LINE_W-1:0];

      meta_in.vld   = ctl.accept;
      meta_in.row   = r;
      meta_in.col   = c;
      meta_in.hy_en = ctl.accept && (r != '0) && (c != '0) && (c < n);
      meta_in.hx_en = ctl.accept && (r != '0) && (r < n) && (c != '0);
      meta_in.last  = (r == n) && (c == n);

      if (c >= n) begin
         col_in = '0;
         row_in = (r >= n) ? '0 : r + fdtdh_pkg::POS_W'(1);
      end else begin
         col_in = c + fdtdh_pkg::POS_W'(1);
         row_in = r;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         line_mem[line_idx] <= ez_value;
      end
      if (ctl.advance) begin
         line_s1_ff <= line_mem[line_idx];
         ez_s1_ff   <= ez_value;
         prev_s1_ff <= prev_ez_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff     <= '0;
         col_ff     <= '0;
         prev_ez_ff <= '0;
         meta_s1_ff <= '0;
      end else begin
         if (ctl.accept) begin
            row_ff     <= row_in;
            col_ff     <= col_in;
            prev_ez_ff <= ez_value;
         end
         if (ctl.advance) begin
            meta_s1_ff <= meta_in;
         end
      end
   end

   assign meta_s1 = meta_s1_ff;
   assign ez_s1   = ez_s1_ff;
   assign line_s1 = line_s1_ff;
   assign prev_s1 = prev_s1_ff;

endmodule

// ===== rtl/core/fdtdh_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdtdh_update
// One H component: field store, scaled difference and saturating update.
// ----------------------------------------------------------------------------
module fdtdh_update (
   input  logic                               clock,
   input  logic                               reset,
   input  fdtdh_pkg::pipe_ctl_type            ctl,
   input  logic [fdtdh_pkg::COEF_W-1:0]       coefficient,
   input  logic [fdtdh_pkg::ADDR_W-1:0]       rd_addr,
   input  logic [fdtdh_pkg::DATA_W-1:0]       minuend,
   input  logic [fdtdh_pkg::DATA_W-1:0]       subtrahend,
   input  logic                               en_s1,
   output logic [fdtdh_pkg::DATA_W-1:0]       h_value
);

   logic [fdtdh_pkg::DATA_W-1:0] store_mem [fdtdh_pkg::STORE_DEPTH];

   logic [fdtdh_pkg::DATA_W-1:0] h_rd_ff, h_s2_ff;
   logic [fdtdh_pkg::ADDR_W-1:0] addr_s1_ff, addr_s2_ff;
   logic [fdtdh_pkg::PROD_W-1:0] prod_s2_ff, prod_in;
   logic                         neg_s2_ff, en_s2_ff;

   logic [fdtdh_pkg::DIFF_W-1:0] diff, diff_neg;
   logic                         neg_in;
   logic [fdtdh_pkg::DATA_W-1:0] mag;
   logic [fdtdh_pkg::PROD_W-1:0] rounded;
   logic [fdtdh_pkg::QUOT_W-1:0] quot;
   logic [fdtdh_pkg::SUM_W-1:0]  delta, sum;
   logic [fdtdh_pkg::DATA_W-1:0] sat;
   logic                         wr_en;

   always_comb begin
      diff     = {minuend[fdtdh_pkg::DATA_W-1], minuend}
               - {subtrahend[fdtdh_pkg::DATA_W-1], subtrahend};
      diff_neg = -diff;
      neg_in   = diff[fdtdh_pkg::DIFF_W-1];
      mag      = neg_in ? diff_neg[fdtdh_pkg::DATA_W-1:0] : diff[fdtdh_pkg::DATA_W-1:0];
      prod_in  = fdtdh_pkg::PROD_W'(mag) * fdtdh_pkg::PROD_W'(coefficient);
   end

   always_comb begin
      rounded = prod_s2_ff + (fdtdh_pkg::PROD_W'(1) << (fdtdh_pkg::COEF_FRAC - 1));
      quot    = rounded[fdtdh_pkg::PROD_W-1:fdtdh_pkg::COEF_FRAC];
      delta   = neg_s2_ff ? -fdtdh_pkg::SUM_W'(quot) : fdtdh_pkg::SUM_W'(quot);
      sum     = {{(fdtdh_pkg::SUM_W - fdtdh_pkg::DATA_W){h_s2_ff[fdtdh_pkg::DATA_W-1]}},
                 h_s2_ff} + delta;
      if (sum[fdtdh_pkg::SUM_W-1:fdtdh_pkg::DATA_W-1] == '0
          || sum[fdtdh_pkg::SUM_W-1:fdtdh_pkg::DATA_W-1] == '1) begin
         sat = sum[fdtdh_pkg::DATA_W-1:0];
      end else if (sum[fdtdh_pkg::SUM_W-1]) begin
         sat = {1'b1, {(fdtdh_pkg::DATA_W-1){1'b0}}};
      end else begin
         sat = {1'b0, {(fdtdh_pkg::DATA_W-1){1'b1}}};
      end
      wr_en   = ctl.advance && en_s2_ff;
      h_value = en_s2_ff ? sat : '0;
   end

   always_ff @(posedge clock) begin
      if (ctl.clearing) begin
         store_mem[ctl.clear_addr] <= '0;
      end else if (wr_en) begin
         store_mem[addr_s2_ff] <= sat;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         h_rd_ff    <= store_mem[rd_addr];
         addr_s1_ff <= rd_addr;
         h_s2_ff    <= h_rd_ff;
         addr_s2_ff <= addr_s1_ff;
         prod_s2_ff <= prod_in;
         neg_s2_ff  <= neg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         en_s2_ff <= 1'b0;
      end else if (ctl.advance) begin
         en_s2_ff <= en_s1;
      end
   end

endmodule

// ===== rtl/core/fdtd_2d_h_field_update_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdtd_2d_h_field_update_top
// Magnetic field step of a 2-D TM Yee grid, updated in place from streamed Ez.
// ----------------------------------------------------------------------------
// Usage:
//   Stream one time step's Ez grid, (N+1) x (N+1) samples in raster order, on
//   the req_ channel; req_frame_start marks the first sample. Each sample gives
//   exactly one item on the rsp_ channel with the updated Hy(row-1,col) and/or
//   Hx(row,col-1) cell where one applies, the sample position and an end-of-grid flag.
//   Configure grid_size and coefficient over the APB port while idle.
// Timing:
//   One item per cycle sustained while rsp_stall and the store sweep do not hold
//   the pipeline. The stages are store read, multiply, round and saturate with
//   write back. The store write port takes one write per cycle per component.
// Reset:
//   After reset both H stores are swept to zero, one word per cycle across all
//   4160 words of each; req_stall stays high during the sweep. APB writes are
//   taken throughout.
// Stall:
//   When rsp_stall holds a waiting item, the whole pipeline freezes and
//   req_stall rises in the same cycle; no item is lost or repeated.
// ----------------------------------------------------------------------------
module fdtd_2d_h_field_update_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [31:0]                 req_ez_value,
   input  logic                               req_frame_start,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_hy_valid,
   output logic signed [31:0]                 rsp_hy_value,
   output logic                               rsp_hx_valid,
   output logic signed [31:0]                 rsp_hx_value,
   output logic [6:0]                         rsp_ez_row,
   output logic [6:0]                         rsp_ez_col,
   output logic                               rsp_frame_last,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [fdtdh_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [fdtdh_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [fdtdh_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                               pready
);

   fdtdh_pkg::cfg_type           cfg;
   fdtdh_pkg::pipe_ctl_type      ctl;
   fdtdh_pkg::stage_type         meta_s1, meta_s2_ff;

   logic                         clear_ff;
   logic [fdtdh_pkg::ADDR_W-1:0] clear_addr_ff;
   logic                         advance, accept;

   logic [fdtdh_pkg::ADDR_W-1:0] hy_addr, hx_addr;
   logic [fdtdh_pkg::DATA_W-1:0] ez_s1, line_s1, prev_s1;
   logic [fdtdh_pkg::DATA_W-1:0] hy_s2, hx_s2;

   logic                         rsp_valid_ff, rsp_hy_valid_ff, rsp_hx_valid_ff;
   logic [fdtdh_pkg::DATA_W-1:0] rsp_hy_value_ff, rsp_hx_value_ff;
   logic [fdtdh_pkg::POS_W-1:0]  rsp_ez_row_ff, rsp_ez_col_ff;
   logic                         rsp_frame_last_ff;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = clear_ff || !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      ctl.advance    = advance;
      ctl.accept     = accept;
      ctl.clearing   = clear_ff;
      ctl.clear_addr = clear_addr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff      <= 1'b1;
         clear_addr_ff <= '0;
      end else if (clear_ff) begin
         if (clear_addr_ff == fdtdh_pkg::ADDR_W'(fdtdh_pkg::STORE_DEPTH - 1)) begin
            clear_ff <= 1'b0;
         end
         clear_addr_ff <= clear_addr_ff + fdtdh_pkg::ADDR_W'(1);
      end
   end

   fdtdh_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   fdtdh_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .grid_size   (cfg.grid_size),
      .ez_value    (req_ez_value),
      .frame_start (req_frame_start),
      .hy_addr     (hy_addr),
      .hx_addr     (hx_addr),
      .meta_s1     (meta_s1),
      .ez_s1       (ez_s1),
      .line_s1     (line_s1),
      .prev_s1     (prev_s1)
   );

   fdtdh_update u_hy (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .coefficient (cfg.coefficient),
      .rd_addr     (hy_addr),
      .minuend     (ez_s1),
      .subtrahend  (line_s1),
      .en_s1       (meta_s1.hy_en),
      .h_value     (hy_s2)
   );

   fdtdh_update u_hx (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .coefficient (cfg.coefficient),
      .rd_addr     (hx_addr),
      .minuend     (prev_s1),
      .subtrahend  (ez_s1),
      .en_s1       (meta_s1.hx_en),
      .h_value     (hx_s2)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         meta_s2_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         meta_s2_ff   <= meta_s1;
         rsp_valid_ff <= meta_s2_ff.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_hy_valid_ff   <= meta_s2_ff.hy_en;
         rsp_hy_value_ff   <= hy_s2;
         rsp_hx_valid_ff   <= meta_s2_ff.hx_en;
         rsp_hx_value_ff   <= hx_s2;
         rsp_ez_row_ff     <= meta_s2_ff.row;
         rsp_ez_col_ff     <= meta_s2_ff.col;
         rsp_frame_last_ff <= meta_s2_ff.last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hy_valid   = rsp_hy_valid_ff;
   assign rsp_hy_value   = rsp_hy_value_ff;
   assign rsp_hx_valid   = rsp_hx_valid_ff;
   assign rsp_hx_value   = rsp_hx_value_ff;
   assign rsp_ez_row     = rsp_ez_row_ff;
   assign rsp_ez_col     = rsp_ez_col_ff;
   assign rsp_frame_last = rsp_frame_last_ff;

   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      clear_ff |-> !(meta_s1.vld || meta_s2_ff.vld || rsp_valid_ff))
      else $error("pipeline holds an item during the store sweep");

   a_last_no_update: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_last) |->
         (rsp_ez_row == rsp_ez_col && !rsp_hy_valid && !rsp_hx_valid))
      else $error("last grid sample carries an H update");

   a_idle_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_hy_valid || rsp_hy_value == '0)
                     && (rsp_hx_valid || rsp_hx_value == '0)))
      else $error("H value set without its valid flag");

   a_update_interior: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_hy_valid || rsp_hx_valid)) |->
         (rsp_ez_row != '0 && rsp_ez_col != '0))
      else $error("H update on the first row or column");

endmodule
